### design/blim_pkg.sv
// Shared types and constants for the busy/idle load meter.
`default_nettype none

package blim_pkg;

  // Default accumulator width in bits.
  localparam int TIME_BITS_DEF = 32;

  // Fixed field widths.
  localparam int OPCODE_W = 2;
  localparam int NOW_W    = 32;
  localparam int LOAD_W   = 7;
  localparam int WINDOW_W = 16;

  // Stream data widths, padded to whole bytes.
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 8;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd2000;

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Opcodes as they arrive on the input stream.
  localparam logic [OPCODE_W-1:0] OP_IDLE  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_WAKE  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_QUERY = 2'd2;

  // Classified request kinds.
  typedef enum logic [1:0] {
    KIND_IDLE,
    KIND_WAKE,
    KIND_QUERY
  } blim_kind_t;

  typedef struct packed {
    blim_kind_t        kind;
    logic [NOW_W-1:0]  now;
  } blim_item_t;

endpackage

`default_nettype wire

### design/blim_front.sv
// Input stage: accepts requests, decodes the opcode and drops unused codes.
`default_nettype none

module blim_front (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  input  wire  [blim_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                             q_valid,
  output blim_pkg::blim_item_t             q_item,
  input  wire                              q_ready
);
  import blim_pkg::*;

  logic                  valid_r, valid_nxt;
  blim_item_t            item_r, item_nxt;
  logic [OPCODE_W-1:0]   opcode;
  logic                  known;
  blim_kind_t            kind;

  assign opcode    = in_tdata[OPCODE_W-1:0];
  assign in_tready = !valid_r || q_ready;
  assign q_valid   = valid_r;
  assign q_item    = item_r;

  always_comb begin
    known = 1'b1;
    kind  = KIND_IDLE;
    unique case (opcode)
      OP_IDLE:  kind = KIND_IDLE;
      OP_WAKE:  kind = KIND_WAKE;
      OP_QUERY: kind = KIND_QUERY;
      default:  known = 1'b0;
    endcase
  end

  always_comb begin
    valid_nxt = valid_r && !q_ready;
    item_nxt  = item_r;
    if (in_tvalid && in_tready && known) begin
      valid_nxt     = 1'b1;
      item_nxt.kind = kind;
      item_nxt.now  = in_tdata[OPCODE_W +: NOW_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    item_r <= item_nxt;
  end

endmodule

`default_nettype wire

### design/blim_queue.sv
// Small request queue that decouples the front stage from the back end.
`default_nettype none

module blim_queue #(
  parameter int DEPTH = blim_pkg::QUEUE_DEPTH
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        wr_valid,
  output logic                       wr_ready,
  input  wire blim_pkg::blim_item_t  wr_item,
  output logic                       rd_valid,
  output blim_pkg::blim_item_t       rd_item,
  input  wire                        rd_pop
);
  import blim_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  blim_item_t          mem_r [DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]    count_r;
  logic                do_wr, do_rd;

  assign wr_ready = count_r != CNT_W'(DEPTH);
  assign rd_valid = count_r != '0;
  assign rd_item  = mem_r[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_pop && rd_valid;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= bump(wr_ptr_r);
      end
      if (do_rd) begin
        rd_ptr_r <= bump(rd_ptr_r);
      end
      if (do_wr && !do_rd) begin
        count_r <= count_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - 1'b1;
      end
    end
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

`default_nettype wire

### design/blim_back.sv
// Back end: keeps the mode and accumulators, credits elapsed time and halves.
`default_nettype none

module blim_back #(
  parameter int TIME_BITS = blim_pkg::TIME_BITS_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              q_valid,
  input  wire  blim_pkg::blim_item_t       q_item,
  output logic                             q_pop,
  input  wire  [blim_pkg::WINDOW_W-1:0]    window,
  input  wire                              div_ready,
  output logic                             div_start,
  output logic [TIME_BITS-1:0]             busy_time,
  output logic [TIME_BITS-1:0]             idle_time
);
  import blim_pkg::*;

  localparam int STAMP_W = (TIME_BITS < NOW_W) ? TIME_BITS : NOW_W;
  localparam int SUM_W   = TIME_BITS + 1;

  typedef enum logic [1:0] {
    S_WAIT,
    S_CREDIT,
    S_CHECK
  } state_t;

  state_t               state_r;
  blim_item_t           cur_r;
  logic [STAMP_W-1:0]   last_mark_r;
  logic [TIME_BITS-1:0] busy_r, idle_r;
  logic                 is_idle_r;
  logic                 div_start_r;

  logic                 take;
  logic [STAMP_W-1:0]   stamp, delta;
  logic [TIME_BITS-1:0] acc_sel, acc_new;
  logic [SUM_W-1:0]     acc_sum, total;

  assign take = q_valid &&
                (q_item.kind != KIND_QUERY || (div_ready && !div_start_r));
  assign q_pop = (state_r == S_WAIT) && take;

  // Elapsed time wraps in the timestamp width; the add saturates.
  assign stamp   = cur_r.now[STAMP_W-1:0];
  assign delta   = stamp - last_mark_r;
  assign acc_sel = is_idle_r ? idle_r : busy_r;
  assign acc_sum = {1'b0, acc_sel} + SUM_W'(delta);
  assign acc_new = acc_sum[TIME_BITS] ? '1 : acc_sum[TIME_BITS-1:0];
  assign total   = {1'b0, busy_r} + {1'b0, idle_r};

  assign div_start = div_start_r;
  assign busy_time = busy_r;
  assign idle_time = idle_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_WAIT;
      last_mark_r <= '0;
      busy_r      <= '0;
      idle_r      <= '0;
      is_idle_r   <= 1'b0;
      div_start_r <= 1'b0;
    end else begin
      div_start_r <= 1'b0;
      unique case (state_r)
        S_WAIT: begin
          if (q_pop) begin
            cur_r <= q_item;
            // A sleep while idle or a wake while busy changes nothing.
            if (q_item.kind == KIND_QUERY ||
                (q_item.kind == KIND_IDLE) != is_idle_r) begin
              state_r <= S_CREDIT;
            end
          end
        end
        S_CREDIT: begin
          last_mark_r <= stamp;
          if (is_idle_r) begin
            idle_r <= acc_new;
          end else begin
            busy_r <= acc_new;
          end
          if (cur_r.kind == KIND_QUERY) begin
            div_start_r <= 1'b1;
            state_r     <= S_WAIT;
          end else begin
            is_idle_r <= cur_r.kind == KIND_IDLE;
            state_r   <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (total > SUM_W'(window)) begin
            busy_r <= busy_r >> 1;
            idle_r <= idle_r >> 1;
          end
          state_r <= S_WAIT;
        end
        default: state_r <= S_WAIT;
      endcase
    end
  end

endmodule

`default_nettype wire

### design/blim_div.sv
// Percentage unit: restoring division of 100*busy by busy+idle, one bit a cycle.
`default_nettype none

module blim_div #(
  parameter int TIME_BITS = blim_pkg::TIME_BITS_DEF
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            start,
  input  wire  [TIME_BITS-1:0]           busy_time,
  input  wire  [TIME_BITS-1:0]           idle_time,
  output logic                           ready,
  output logic                           out_valid,
  input  wire                            out_ready,
  output logic [blim_pkg::LOAD_W-1:0]    out_load
);
  import blim_pkg::*;

  // 100*busy fits in TIME_BITS+7 bits, as does the total shifted by 6.
  localparam int NUM_W = TIME_BITS + LOAD_W;
  localparam int SUM_W = TIME_BITS + 1;
  localparam int CNT_W = $clog2(LOAD_W);

  typedef enum logic {
    D_IDLE,
    D_STEP
  } state_t;

  state_t              state_r;
  logic [NUM_W-1:0]    rem_r, dsh_r;
  logic [LOAD_W-2:0]   q_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                zero_r;
  logic                out_valid_r;
  logic [LOAD_W-1:0]   out_load_r;

  logic [SUM_W-1:0]    sum;
  logic [NUM_W-1:0]    b_ext, num;
  logic                ge;

  assign sum   = {1'b0, busy_time} + {1'b0, idle_time};
  assign b_ext = NUM_W'(busy_time);
  assign num   = (b_ext << 6) + (b_ext << 5) + (b_ext << 2);
  assign ge    = rem_r >= dsh_r;

  assign ready     = (state_r == D_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;
  assign out_load  = out_load_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= D_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        D_IDLE: begin
          if (start) begin
            rem_r   <= num;
            dsh_r   <= NUM_W'(sum) << (LOAD_W - 1);
            zero_r  <= sum == '0;
            q_r     <= '0;
            cnt_r   <= CNT_W'(LOAD_W - 1);
            state_r <= D_STEP;
          end
        end
        D_STEP: begin
          if (ge) begin
            rem_r <= rem_r - dsh_r;
          end
          dsh_r <= dsh_r >> 1;
          q_r   <= {q_r[LOAD_W-3:0], ge};
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            // An empty history reads as zero load.
            out_load_r  <= zero_r ? '0 : {q_r, ge};
            out_valid_r <= 1'b1;
            state_r     <= D_IDLE;
          end
        end
        default: state_r <= D_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### design/busy_idle_load_meter.sv
// Top level of the busy/idle load meter.
//
// The block measures how busy an agent is. Each request on the in_ stream
// carries an opcode (going idle, waking busy, or query) and a millisecond
// timestamp. A real mode change credits the time since the last mark to the
// idle or busy accumulator and halves both when their sum exceeds window_ms.
// A query credits the elapsed time and returns one out_ request with the
// busy share in percent; mode events and repeated modes return nothing.
// The window register is written through cfg_wr_en/cfg_wr_data; the user
// must write it only while idle, as the block does not enforce this.
// Requests pass a decode register and a two-entry queue to the back end,
// so the input keeps flowing while a result waits on out_. A query passes
// the decode register, the queue, the back end's pop and credit states,
// the divider load and seven one-bit-per-cycle divide steps before its
// result shows on out_; the divider sets the pace of queries. A mode
// change passes the back end's pop, credit and check states, a repeated
// mode only the pop. Only one query is in the divider at a time, and a new
// query waits until the previous result has been taken; when the receiver
// stalls, the queue fills and in_tready drops.
// Reset clears the accumulators, the mark and the mode (busy), restores the
// window to 2000 ms and empties the queue and output register.
`default_nettype none

module busy_idle_load_meter #(
  parameter int TIME_BITS = blim_pkg::TIME_BITS_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  // [1:0] opcode, [33:2] now_ms, [39:34] zero
  input  wire  [blim_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                             out_tvalid,
  input  wire                              out_tready,
  // [6:0] load_percent, [7] zero
  output logic [blim_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  wire                              cfg_wr_en,
  input  wire  [blim_pkg::WINDOW_W-1:0]    cfg_wr_data
);
  import blim_pkg::*;

  logic [WINDOW_W-1:0]  window_r;
  logic                 fq_valid, fq_ready;
  blim_item_t           fq_item;
  logic                 bq_valid, bq_pop;
  blim_item_t           bq_item;
  logic                 div_ready, div_start;
  logic [TIME_BITS-1:0] busy_time, idle_time;
  logic [LOAD_W-1:0]    load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RESET;
    end else if (cfg_wr_en) begin
      window_r <= cfg_wr_data;
    end
  end

  blim_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_valid   (fq_valid),
    .q_item    (fq_item),
    .q_ready   (fq_ready)
  );

  blim_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_item  (fq_item),
    .rd_valid (bq_valid),
    .rd_item  (bq_item),
    .rd_pop   (bq_pop)
  );

  blim_back #(
    .TIME_BITS (TIME_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (bq_valid),
    .q_item    (bq_item),
    .q_pop     (bq_pop),
    .window    (window_r),
    .div_ready (div_ready),
    .div_start (div_start),
    .busy_time (busy_time),
    .idle_time (idle_time)
  );

  blim_div #(
    .TIME_BITS (TIME_BITS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .busy_time (busy_time),
    .idle_time (idle_time),
    .ready     (div_ready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_load  (load)
  );

  assign out_tdata = OUT_TDATA_W'(load);

endmodule

`default_nettype wire

### design/blim_checker.sv
// Port-level checks on the load meter output, bound to the top level.
`default_nettype none

module blim_checker (
  input wire                              clk,
  input wire                              rst_n,
  input wire                              out_tvalid,
  input wire                              out_tready,
  input wire [blim_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  // The output register is empty right after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // A stalled result stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // A percentage never exceeds one hundred.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[6:0] <= 7'd100)
    else $error("load percent out of range");

  // The pad bit stays zero.
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[7])
    else $error("nonzero pad bit");

  // Results come from a multi-cycle divide, so two cannot be back to back.
  a_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready |=> !out_tvalid)
    else $error("results too close together");

endmodule

bind busy_idle_load_meter blim_checker u_blim_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
